// ===== rtl/core/bounded_ordered_list_engine_assert.svh =====
// Assertion macros shared by the bounded ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define BOLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define BOLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bole_pkg.sv =====
// Shared types and constants of the bounded ordered list engine.
package bole_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int ACT_W      = 4;
	localparam int POS_W      = 5;
	localparam int DIN_W      = 32;
	localparam int DOUT_W     = 32;
	localparam int FPOS_W     = 5;
	localparam int CNT_OUT_W  = 5;
	localparam int STAT_W     = 2;

	localparam logic [ACT_W-1:0] ACT_ADD_FRONT    = 4'd0;
	localparam logic [ACT_W-1:0] ACT_ADD_BACK     = 4'd1;
	localparam logic [ACT_W-1:0] ACT_INSERT_AT    = 4'd2;
	localparam logic [ACT_W-1:0] ACT_REMOVE_FRONT = 4'd3;
	localparam logic [ACT_W-1:0] ACT_REMOVE_BACK  = 4'd4;
	localparam logic [ACT_W-1:0] ACT_REMOVE_AT    = 4'd5;
	localparam logic [ACT_W-1:0] ACT_READ_AT      = 4'd6;
	localparam logic [ACT_W-1:0] ACT_FIND         = 4'd7;
	localparam logic [ACT_W-1:0] ACT_CLEAR        = 4'd8;

	localparam logic [STAT_W-1:0] STS_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STS_RANGE     = 2'd1;
	localparam logic [STAT_W-1:0] STS_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] STS_NOT_FOUND = 2'd3;

	localparam logic signed [FPOS_W-1:0] NO_POSITION = -5'sd1;

	typedef struct packed {
		logic exec;       // carry out a non-find request this cycle
		logic scan_load;  // start a find scan
		logic scan_step;  // move the scan to the next entry
		logic scan_fin;   // scan has ended, capture its result
		logic scanning;   // a find scan is in progress
		logic advance;    // move the held result into the output register
	} cmd_t;

	typedef struct packed {
		logic is_find;
		logic scan_done;
	} sts_t;

endpackage

// ===== rtl/core/bole_ctrl.sv =====
// Controller of the bounded ordered list engine: handshakes and find-scan sequencing.
module bole_ctrl import bole_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic state_d;
	logic valid_s1;
	logic valid_s2;
	logic accept;
	logic advance;

	// The held result moves on when the output register is empty or being taken.
	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = !((state_q == ST_IDLE) && (!valid_s1 || advance));
	assign accept    = req_valid && !req_stall;

	always_comb begin
		cmd.exec      = accept && !sts.is_find;
		cmd.scan_load = accept && sts.is_find;
		cmd.scanning  = (state_q == ST_SCAN);
		cmd.scan_fin  = (state_q == ST_SCAN) && sts.scan_done;
		cmd.scan_step = (state_q == ST_SCAN) && !sts.scan_done;
		cmd.advance   = advance;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.scan_load) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec || cmd.scan_fin) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) valid_s2 <= 1'b1;
			else if (!rsp_stall) valid_s2 <= 1'b0;
		end
	end

	assign rsp_valid = valid_s2;

endmodule

// ===== rtl/core/bole_dpath.sv =====
// Datapath of the bounded ordered list engine: shifting entry cells, count, scan and result stages.
module bole_dpath import bole_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [ACT_W-1:0]         action,
	input  logic [POS_W-1:0]         position,
	input  logic [DIN_W-1:0]         data_in,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	output logic [DOUT_W-1:0]        data_out,
	output logic signed [FPOS_W-1:0] found_position,
	output logic [CNT_OUT_W-1:0]     count,
	output logic [STAT_W-1:0]        status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nx;
	logic [CNT_W-1:0]      idx_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [DATA_WIDTH-1:0] val_in;

	logic is_add, is_rem, is_read, is_find, is_clear;
	logic full, empty, pos_oob, rem_bad;
	logic ins_en, rem_en, clr_en;
	logic [IDX_W-1:0] ins_at, rem_at, rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;
	logic in_range, hit;

	logic [DATA_WIDTH-1:0]     res_data;
	logic signed [FPOS_W-1:0]  res_found;
	logic [CNT_W-1:0]          res_count;
	logic [STAT_W-1:0]         res_status;

	logic [DATA_WIDTH-1:0]     data_s1, data_s2;
	logic signed [FPOS_W-1:0]  found_s1, found_s2;
	logic [CNT_W-1:0]          count_s1, count_s2;
	logic [STAT_W-1:0]         status_s1, status_s2;

	assign val_in = DATA_WIDTH'(data_in);

	always_comb begin
		is_add   = 1'b0;
		is_rem   = 1'b0;
		is_read  = 1'b0;
		is_find  = 1'b0;
		is_clear = 1'b0;
		unique case (action) inside
			ACT_ADD_FRONT, ACT_ADD_BACK, ACT_INSERT_AT:          is_add   = 1'b1;
			ACT_REMOVE_FRONT, ACT_REMOVE_BACK, ACT_REMOVE_AT:    is_rem   = 1'b1;
			ACT_READ_AT:                                         is_read  = 1'b1;
			ACT_FIND:                                            is_find  = 1'b1;
			ACT_CLEAR:                                           is_clear = 1'b1;
			default: ;
		endcase
	end

	assign full    = (count_q == CNT_W'(CAPACITY));
	assign empty   = (count_q == '0);
	assign pos_oob = (CMP_W'(position) >= CMP_W'(count_q));
	assign rem_bad = empty || ((action == ACT_REMOVE_AT) && pos_oob);

	always_comb begin
		case (action)
			ACT_ADD_FRONT: ins_at = '0;
			ACT_INSERT_AT: ins_at = pos_oob ? IDX_W'(count_q) : IDX_W'(position);
			default:       ins_at = IDX_W'(count_q);
		endcase
		case (action)
			ACT_REMOVE_FRONT: rem_at = '0;
			ACT_REMOVE_BACK:  rem_at = IDX_W'(count_q - 1'b1);
			default:          rem_at = IDX_W'(position);
		endcase
	end

	assign ins_en = cmd.exec && is_add && !full;
	assign rem_en = cmd.exec && is_rem && !rem_bad;
	assign clr_en = cmd.exec && is_clear;

	// One read port: scan index during a find, removal index for removes, else the request's position.
	always_comb begin
		if (cmd.scanning) rd_addr = idx_q[IDX_W-1:0];
		else if (is_rem) rd_addr = rem_at;
		else rd_addr = IDX_W'(position);
	end
	assign rd_data = cell_q[rd_addr];

	// Each cell loads the new value, takes its lower neighbor on insert,
	// or takes its upper neighbor on remove.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower;
		logic [DATA_WIDTH-1:0] upper;
		if (i == 0) begin : g_first
			assign lower = val_in;
		end else begin : g_lower
			assign lower = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper = cell_q[i];
		end else begin : g_upper
			assign upper = cell_q[i+1];
		end
		always_ff @(posedge clk) begin
			if (ins_en && (ins_at == IDX_W'(i))) cell_q[i] <= val_in;
			else if (ins_en && (ins_at < IDX_W'(i))) cell_q[i] <= lower;
			else if (rem_en && (rem_at <= IDX_W'(i))) cell_q[i] <= upper;
		end
	end

	always_comb begin
		count_nx = count_q;
		if (ins_en) count_nx = count_q + 1'b1;
		else if (rem_en) count_nx = count_q - 1'b1;
		else if (clr_en) count_nx = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			count_q <= count_nx;
			if (cmd.scan_load) idx_q <= '0;
			else if (cmd.scan_step) idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_load) val_q <= val_in;
	end

	assign in_range      = (idx_q < count_q);
	assign hit           = in_range && (rd_data == val_q);
	assign sts.scan_done = !in_range || hit;
	assign sts.is_find   = is_find;

	always_comb begin
		res_data   = '0;
		res_found  = NO_POSITION;
		res_count  = count_nx;
		res_status = STS_OK;
		if (cmd.scanning) begin
			res_count = count_q;
			if (hit) res_found = FPOS_W'(idx_q);
			else res_status = STS_NOT_FOUND;
		end else if (is_add) begin
			if (full) res_status = STS_FULL;
		end else if (is_rem) begin
			if (rem_bad) res_status = STS_RANGE;
			else res_data = rd_data;
		end else if (is_read) begin
			if (pos_oob) res_status = STS_RANGE;
			else res_data = rd_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.scan_fin) begin
			data_s1   <= res_data;
			found_s1  <= res_found;
			count_s1  <= res_count;
			status_s1 <= res_status;
		end
		if (cmd.advance) begin
			data_s2   <= data_s1;
			found_s2  <= found_s1;
			count_s2  <= count_s1;
			status_s2 <= status_s1;
		end
	end

	assign data_out       = DOUT_W'(data_s2);
	assign found_position = found_s2;
	assign count          = CNT_OUT_W'(count_s2);
	assign status         = status_s2;

endmodule

// ===== rtl/core/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+---------------------------------------------
//  request  | req_valid, req_stall  | action, position, data_in
//  response | rsp_valid, rsp_stall  | data_out, found_position, count, status
//
// Every request except find is handled as it arrives: a new item can enter each cycle while
// the response is not stalled, and its result moves through the result and output registers.
// A find walks the entries through the single read port, one compare per cycle, and
// stalls requests until the scan hits or runs past the last entry.
// Reset empties the list at once; entry contents are not cleared.
// A stalled response holds; one further item is accepted into the holding stage
// behind it before requests are stalled.
`include "bounded_ordered_list_engine_assert.svh"

module bounded_ordered_list_engine import bole_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [ACT_W-1:0]         action,
	input  logic [POS_W-1:0]         position,
	input  logic [DIN_W-1:0]         data_in,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [DOUT_W-1:0]        data_out,
	output logic signed [FPOS_W-1:0] found_position,
	output logic [CNT_OUT_W-1:0]     count,
	output logic [STAT_W-1:0]        status
);

	cmd_t cmd;
	sts_t sts;

	bole_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bole_dpath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.action         (action),
		.position       (position),
		.data_in        (data_in),
		.cmd            (cmd),
		.sts            (sts),
		.data_out       (data_out),
		.found_position (found_position),
		.count          (count),
		.status         (status)
	);

	`BOLE_ASSERT_NEXT(a_scan_starts, cmd.scan_load, cmd.scanning, "find did not start a scan")
	`BOLE_ASSERT_NOW(a_scan_blocks_req, cmd.scanning, req_stall, "request taken during a scan")
	`BOLE_ASSERT_NOW(a_miss_position, rsp_valid && (status == STS_NOT_FOUND),
		found_position == NO_POSITION, "not found without no-position")
	`BOLE_ASSERT_NOW(a_full_count, rsp_valid && (status == STS_FULL),
		count == CNT_OUT_W'(CAPACITY), "full status with list not full")

endmodule

// ===== tb/bounded_ordered_list_engine_test.sv =====
// Self-checking testbench for the bounded ordered list engine: directed script, then random phases.
module bounded_ordered_list_engine_test;
	import bole_pkg::*;

	localparam int LIST_DEPTH = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 254;
	localparam int HOLDOFF_CYCLES = 100;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_PRINTED = 40;
	localparam logic [ACT_W-1:0] ACT_UNUSED_LOW = 4'd9;
	localparam logic [ACT_W-1:0] ACT_UNUSED_HIGH = 4'd15;

	typedef struct packed {
		logic [DOUT_W-1:0] data_out;
		logic signed [FPOS_W-1:0] found_position;
		logic [CNT_OUT_W-1:0] count;
		logic [STAT_W-1:0] status;
	} list_rsp_t;

	typedef struct {
		logic [ACT_W-1:0] act;
		logic [POS_W-1:0] pos;
		logic [DIN_W-1:0] data;
		int reps;
		bit pinned;
		list_rsp_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [ACT_W-1:0] action = '0;
	logic [POS_W-1:0] position = '0;
	logic [DIN_W-1:0] data_in = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [DOUT_W-1:0] data_out;
	logic signed [FPOS_W-1:0] found_position;
	logic [CNT_OUT_W-1:0] count;
	logic [STAT_W-1:0] status;

	// Rows with a typed expectation travel alongside the payload.
	bit item_pinned = 1'b0;
	list_rsp_t item_pinned_rsp = '0;

	logic [DIN_W-1:0] list_words [LIST_DEPTH];
	int list_len = 0;
	list_rsp_t results_due_q [$];
	script_row_t script_q [$];

	int mismatch_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	bit holdoff_arm = 1'b0;
	int holdoff_left = 0;

	bounded_ordered_list_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.position(position),
		.data_in(data_in),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.data_out(data_out),
		.found_position(found_position),
		.count(count),
		.status(status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		if (mismatch_count < MAX_PRINTED)
			$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// Applies one request to the shadow list and returns the result it must produce.
	function automatic list_rsp_t list_apply(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
			logic [DIN_W-1:0] val);
		list_rsp_t r;
		int at;
		int i;
		r.data_out = '0;
		r.found_position = NO_POSITION;
		r.count = '0;
		r.status = STS_OK;
		case (act)
			ACT_ADD_FRONT, ACT_ADD_BACK, ACT_INSERT_AT: begin
				if (list_len >= LIST_DEPTH) begin
					r.status = STS_FULL;
				end else begin
					if (act == ACT_ADD_FRONT)
						at = 0;
					else if (act == ACT_ADD_BACK || int'(pos) >= list_len)
						at = list_len;
					else
						at = int'(pos);
					for (i = list_len; i > at; i--)
						list_words[i] = list_words[i - 1];
					list_words[at] = val;
					list_len++;
				end
			end
			ACT_REMOVE_FRONT, ACT_REMOVE_BACK, ACT_REMOVE_AT: begin
				if (act == ACT_REMOVE_FRONT)
					at = 0;
				else if (act == ACT_REMOVE_BACK)
					at = list_len - 1;
				else
					at = int'(pos);
				if (list_len == 0 || at >= list_len) begin
					r.status = STS_RANGE;
				end else begin
					r.data_out = list_words[at];
					for (i = at; i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
				end
			end
			ACT_READ_AT: begin
				if (int'(pos) >= list_len)
					r.status = STS_RANGE;
				else
					r.data_out = list_words[pos];
			end
			ACT_FIND: begin
				r.status = STS_NOT_FOUND;
				for (i = 0; i < list_len; i++) begin
					if (r.status == STS_NOT_FOUND && list_words[i] == val) begin
						r.found_position = FPOS_W'(i);
						r.status = STS_OK;
					end
				end
			end
			ACT_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		r.count = CNT_OUT_W'(list_len);
		return r;
	endfunction

	// Result that needs no find hit: found_position is always the no-position code.
	function automatic list_rsp_t fixed_rsp(logic [DOUT_W-1:0] dout, logic [CNT_OUT_W-1:0] cnt,
			logic [STAT_W-1:0] sts);
		list_rsp_t r;
		r.data_out = dout;
		r.found_position = NO_POSITION;
		r.count = cnt;
		r.status = sts;
		return r;
	endfunction

	task automatic add_script_row(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
			logic [DIN_W-1:0] data, int reps, bit pinned, list_rsp_t want);
		script_row_t row;
		row.act = act;
		row.pos = pos;
		row.data = data;
		row.reps = reps;
		row.pinned = pinned;
		row.want = want;
		script_q.push_back(row);
	endtask

	// Mostly well-formed traffic that steers the fill level toward a goal, plus some noise.
	function automatic void pick_request(int goal, output logic [ACT_W-1:0] a,
			output logic [POS_W-1:0] p, output logic [DIN_W-1:0] d);
		int roll;
		int data_roll;
		roll = $urandom_range(99);
		data_roll = $urandom_range(99);
		if (list_len > 0 && data_roll < 40)
			d = list_words[$urandom_range(list_len - 1)];
		else if (data_roll < 65)
			d = DIN_W'($urandom_range(3));
		else
			d = $urandom;
		if ($urandom_range(99) < 80)
			p = POS_W'($urandom_range(list_len));
		else
			p = POS_W'($urandom_range(31));
		if (roll < 8) begin
			a = ACT_W'($urandom_range(15));
			p = POS_W'($urandom_range(31));
		end else if (roll < 10) begin
			a = ACT_CLEAR;
		end else if (list_len < goal || (list_len == goal && roll < 40)) begin
			case ($urandom_range(2))
				0: a = ACT_ADD_FRONT;
				1: a = ACT_ADD_BACK;
				default: a = ACT_INSERT_AT;
			endcase
		end else if (list_len > goal || roll < 60) begin
			case ($urandom_range(2))
				0: a = ACT_REMOVE_FRONT;
				1: a = ACT_REMOVE_BACK;
				default: a = ACT_REMOVE_AT;
			endcase
		end else if (roll < 80) begin
			a = ACT_READ_AT;
		end else begin
			a = ACT_FIND;
		end
	endfunction

	// Drives one item from the falling edge and holds it until the block takes it.
	task automatic offer_request(bit gen, int goal, logic [ACT_W-1:0] a, logic [POS_W-1:0] p,
			logic [DIN_W-1:0] d, bit pinned, list_rsp_t want);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		if (gen)
			pick_request(goal, a, p, d);
		req_valid <= 1'b1;
		action <= a;
		position <= p;
		data_in <= d;
		item_pinned <= pinned;
		item_pinned_rsp <= want;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (results_due_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, bit long_hold, int n_items);
		int goal;
		int run_left;
		int done;
		@(posedge clk);
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		if (long_hold)
			holdoff_arm = 1'b1;
		done = 0;
		while (done < n_items) begin
			run_left = $urandom_range(10, 40);
			case ($urandom_range(4))
				0: goal = 0;
				1: goal = LIST_DEPTH;
				2: goal = LIST_DEPTH - 1;
				default: goal = $urandom_range(1, LIST_DEPTH - 2);
			endcase
			while (run_left > 0 && done < n_items) begin
				offer_request(1'b1, goal, '0, '0, '0, 1'b0, '0);
				run_left--;
				done++;
			end
		end
		wait_for_results();
	endtask

	// The receiver either honors a long hold-off or stalls at random.
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			rsp_stall <= 1'b1;
			holdoff_left--;
		end else if (holdoff_arm) begin
			holdoff_arm = 1'b0;
			holdoff_left = HOLDOFF_CYCLES - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		list_rsp_t want;
		list_rsp_t calc;
		if (arst_n) begin
			// A result is never for the item taken at the same edge, so check first.
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				if (results_due_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: data_out %h count %0d",
						data_out, count));
				end else begin
					want = results_due_q.pop_front();
					if (data_out !== want.data_out)
						report_mismatch($sformatf("data_out got %h expected %h",
							data_out, want.data_out));
					if (found_position !== want.found_position)
						report_mismatch($sformatf("found_position got %0d expected %0d",
							found_position, want.found_position));
					if (count !== want.count)
						report_mismatch($sformatf("count got %0d expected %0d", count, want.count));
					if (status !== want.status)
						report_mismatch($sformatf("status got %0d expected %0d", status, want.status));
				end
			end
			if (req_valid === 1'b1 && req_stall === 1'b0) begin
				calc = list_apply(action, position, data_in);
				results_due_q.push_back(item_pinned ? item_pinned_rsp : calc);
			end
		end
	end

	initial begin
		script_row_t row;
		int k;
		// Empty list: every removal and read is out of range and find misses.
		add_script_row(ACT_REMOVE_FRONT, 5'd0, 32'h0, 1, 1'b1, fixed_rsp('0, 5'd0, STS_RANGE));
		add_script_row(ACT_REMOVE_BACK, 5'd0, 32'h0, 1, 1'b1, fixed_rsp('0, 5'd0, STS_RANGE));
		add_script_row(ACT_READ_AT, 5'd0, 32'h0, 1, 1'b1, fixed_rsp('0, 5'd0, STS_RANGE));
		add_script_row(ACT_FIND, 5'd0, 32'h0, 1, 1'b1, fixed_rsp('0, 5'd0, STS_NOT_FOUND));
		add_script_row(ACT_ADD_BACK, 5'd0, 32'hFFFF_FFFF, 1, 1'b1, fixed_rsp('0, 5'd1, STS_OK));
		add_script_row(ACT_ADD_FRONT, 5'd0, 32'h0, 1, 1'b1, fixed_rsp('0, 5'd2, STS_OK));
		// Insert past the end appends; insert at zero goes to the front.
		add_script_row(ACT_INSERT_AT, 5'd31, 32'hA5A5_A5A5, 1, 1'b1, fixed_rsp('0, 5'd3, STS_OK));
		add_script_row(ACT_INSERT_AT, 5'd0, 32'h5A5A_5A5A, 1, 1'b1, fixed_rsp('0, 5'd4, STS_OK));
		add_script_row(ACT_INSERT_AT, 5'd2, 32'h1234_5678, 1, 1'b1, fixed_rsp('0, 5'd5, STS_OK));
		add_script_row(ACT_ADD_BACK, 5'd0, 32'h00C0_FFE0, 11, 1'b0, '0);
		// The list is full now.
		add_script_row(ACT_ADD_FRONT, 5'd0, 32'h1, 1, 1'b1, fixed_rsp('0, 5'd16, STS_FULL));
		add_script_row(ACT_INSERT_AT, 5'd5, 32'h2, 1, 1'b1, fixed_rsp('0, 5'd16, STS_FULL));
		add_script_row(ACT_ADD_BACK, 5'd0, 32'h3, 1, 1'b1, fixed_rsp('0, 5'd16, STS_FULL));
		add_script_row(ACT_READ_AT, 5'd15, 32'h0, 1, 1'b0, '0);
		add_script_row(ACT_READ_AT, 5'd16, 32'h0, 1, 1'b1, fixed_rsp('0, 5'd16, STS_RANGE));
		add_script_row(ACT_READ_AT, 5'd31, 32'h0, 1, 1'b1, fixed_rsp('0, 5'd16, STS_RANGE));
		add_script_row(ACT_FIND, 5'd0, 32'hFFFF_FFFF, 1, 1'b0, '0);
		add_script_row(ACT_FIND, 5'd0, 32'hDEAD_BEEF, 1, 1'b1, fixed_rsp('0, 5'd16, STS_NOT_FOUND));
		add_script_row(ACT_REMOVE_AT, 5'd2, 32'h0, 1, 1'b0, '0);
		add_script_row(ACT_REMOVE_AT, 5'd15, 32'h0, 1, 1'b1, fixed_rsp('0, 5'd15, STS_RANGE));
		add_script_row(ACT_REMOVE_BACK, 5'd0, 32'h0, 1, 1'b0, '0);
		add_script_row(ACT_REMOVE_FRONT, 5'd0, 32'h0, 1, 1'b1,
			fixed_rsp(32'h5A5A_5A5A, 5'd13, STS_OK));
		add_script_row(ACT_UNUSED_LOW, 5'd31, 32'hFFFF_FFFF, 1, 1'b1, fixed_rsp('0, 5'd13, STS_OK));
		add_script_row(ACT_UNUSED_HIGH, 5'd0, 32'h0, 1, 1'b1, fixed_rsp('0, 5'd13, STS_OK));
		add_script_row(ACT_CLEAR, 5'd0, 32'h0, 1, 1'b1, fixed_rsp('0, 5'd0, STS_OK));
		// Stale words past the count must not match after a clear.
		add_script_row(ACT_FIND, 5'd0, 32'h0, 1, 1'b1, fixed_rsp('0, 5'd0, STS_NOT_FOUND));

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script_q[n]) begin
			row = script_q[n];
			for (k = 0; k < row.reps; k++)
				offer_request(1'b0, 0, row.act, row.pos, row.data + k, row.pinned, row.want);
		end
		wait_for_results();

		run_phase(0, 0, 1'b1, PHASE_ITEMS);
		run_phase(69, 0, 1'b0, PHASE_ITEMS);
		run_phase(0, 69, 1'b0, PHASE_ITEMS);
		run_phase(32, 32, 1'b1, PHASE_ITEMS);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_due_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
